@@ hdl/dcdds_pkg.sv @@
// Shared types, constants and the sine table generator for the two-channel DDS.
// No dependencies; used by dcdds_sine_rom and dual_channel_dds_generator_top.
package dcdds_pkg;

  localparam int DAC_W      = 8;
  localparam int DT_W       = 16;
  localparam int SINE_W     = 16;
  localparam int OP_W       = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int AMP_W      = 8;

  localparam logic [SINE_W-1:0] SQUARE_MAG = 16'h8000;
  localparam logic [DAC_W-1:0]  DAC_MID    = 8'd128;

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned Q30_ONE     = 64'd1 << 30;

  typedef enum logic [OP_W-1:0] {
    OP_START = 2'd0,
    OP_STOP  = 2'd1,
    OP_TICK  = 2'd2
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STEP_CH1  = 3'd0,
    CFG_STEP_CH2  = 3'd1,
    CFG_AMP_CH1   = 3'd2,
    CFG_AMP_CH2   = 3'd3,
    CFG_MODE_CH1  = 3'd4,
    CFG_MODE_CH2  = 3'd5,
    CFG_START_CH1 = 3'd6,
    CFG_START_CH2 = 3'd7
  } cfg_idx_t;

  // Quarter-wave sine entry in unsigned Q1.15, Q30 Taylor series; elaboration only.
  function automatic logic [SINE_W-1:0] sine_entry(int unsigned idx, int unsigned qtr_bits);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint unsigned s;
    x  = (HALF_PI_Q30 * longint'(idx)) >> qtr_bits;
    x2 = (x * x) >> 30;
    t  = Q30_ONE - x2 / 110;
    t  = Q30_ONE - ((x2 * t) >> 30) / 72;
    t  = Q30_ONE - ((x2 * t) >> 30) / 42;
    t  = Q30_ONE - ((x2 * t) >> 30) / 20;
    t  = Q30_ONE - ((x2 * t) >> 30) / 6;
    s  = (x * t) >> 30;
    s  = (s + 64'd16384) >> 15;
    if (s > 64'd32768) begin
      s = 64'd32768;
    end
    return SINE_W'(s);
  endfunction

endpackage

@@ hdl/dcdds_sine_rom.sv @@
// Quarter-wave sine table (2^QTR_BITS + 1 entries) with registered read.
// Contents built at elaboration from dcdds_pkg::sine_entry.
module dcdds_sine_rom #(
  parameter int QTR_BITS = 8
) (
  input  logic                          clk,
  input  logic [QTR_BITS:0]             addr,
  output logic [dcdds_pkg::SINE_W-1:0]  rd_data
);

  localparam int ROM_DEPTH = (1 << QTR_BITS) + 1;

  typedef logic [dcdds_pkg::SINE_W-1:0] rom_t [ROM_DEPTH];

  function automatic rom_t build_rom();
    rom_t r;
    for (int i = 0; i < ROM_DEPTH; i++) begin
      r[i] = dcdds_pkg::sine_entry(i, QTR_BITS);
    end
    return r;
  endfunction

  localparam rom_t ROM = build_rom();

  always_ff @(posedge clk) begin
    rd_data <= ROM[addr];
  end

endmodule

@@ hdl/dual_channel_dds_generator_top.sv @@
// Two-channel DDS waveform generator: one shared multiplier under a small sequencer.
// Depends on dcdds_pkg and dcdds_sine_rom.
//
// A tick passes an accept state, then per channel the states step x elapsed time,
// phase add, table read, amplitude x level and code, run one channel after the
// other on the single PHASE_BITS x 16 multiplier, and a done state that loads the
// output register. A stop also gives a result via the done state. The input side
// is not ready while a tick is in progress or a result waits for the output slot.
// A tick while stopped gives no result. Sine uses a quarter-wave table of
// 2^(SINE_ADDR_BITS-2)+1 entries; square, set by the phase's top bit, is full swing at amplitude 255.
module dual_channel_dds_generator_top #(
  parameter int PHASE_BITS     = 32,
  parameter int SINE_ADDR_BITS = 10
) (
  input  logic                                clk,
  input  logic                                rst,
  // config write channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [dcdds_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [dcdds_pkg::CFG_DATA_W-1:0]    cfg_data,
  // input requests
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [dcdds_pkg::DT_W-1:0]          s_axis_tdata,  // [15:0] elapsed_us
  input  logic [dcdds_pkg::OP_W-1:0]          s_axis_tuser,  // [1:0] op
  // results
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [2*dcdds_pkg::DAC_W-1:0]       m_axis_tdata   // [7:0] dac_ch1, [15:8] dac_ch2
);

  localparam int QTR_BITS = SINE_ADDR_BITS - 2;
  localparam int PROD_W   = PHASE_BITS + dcdds_pkg::DT_W;
  localparam int SUM_W    = dcdds_pkg::SINE_W + dcdds_pkg::DAC_W;
  localparam logic [QTR_BITS:0] QTR_LEN  = {1'b1, {QTR_BITS{1'b0}}};
  localparam logic [SUM_W-1:0]  MID_SUM  = {1'b1, {(SUM_W-1){1'b0}}};

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_MUL_STEP = 7'b0000010,
    S_ADD      = 7'b0000100,
    S_ROM      = 7'b0001000,
    S_MUL_AMP  = 7'b0010000,
    S_CODE     = 7'b0100000,
    S_DONE     = 7'b1000000
  } state_t;

  state_t state, state_next;

  logic [PHASE_BITS-1:0]       step_ch1, step_ch2, start_ch1, start_ch2;
  logic [dcdds_pkg::AMP_W-1:0] amp_ch1, amp_ch2;
  logic                        mode_ch1, mode_ch2;

  logic [PHASE_BITS-1:0]       phase_ch1, phase_ch2;
  logic                        running;
  logic                        ch;
  logic [dcdds_pkg::DT_W-1:0]  dt;
  logic [PROD_W-1:0]           prod;
  logic [dcdds_pkg::DAC_W-1:0] dac_ch1, dac_ch2;

  logic [PHASE_BITS-1:0]       cur_phase, cur_step;
  logic [dcdds_pkg::AMP_W-1:0] cur_amp;
  logic                        cur_mode;
  logic [PHASE_BITS-1:0]       mul_a;
  logic [dcdds_pkg::DT_W-1:0]  mul_b;
  logic [SINE_ADDR_BITS-1:0]   wave_addr;
  logic [QTR_BITS:0]           rom_addr;
  logic [dcdds_pkg::SINE_W-1:0] rom_q;
  logic [SUM_W-1:0]            level_sum;
  logic [SUM_W-1:0]            amp_prod;
  logic                        in_acc, out_free;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == S_IDLE);
  assign in_acc        = s_axis_tvalid & s_axis_tready;
  assign out_free      = ~m_axis_tvalid | m_axis_tready;

  assign cur_phase = ch ? phase_ch2 : phase_ch1;
  assign cur_step  = ch ? step_ch2  : step_ch1;
  assign cur_amp   = ch ? amp_ch2   : amp_ch1;
  assign cur_mode  = ch ? mode_ch2  : mode_ch1;

  // quadrant folding: odd quadrants read the table backwards
  assign wave_addr = cur_phase[PHASE_BITS-1 -: SINE_ADDR_BITS];
  assign rom_addr  = wave_addr[QTR_BITS] ? (QTR_LEN - {1'b0, wave_addr[QTR_BITS-1:0]})
                                         : {1'b0, wave_addr[QTR_BITS-1:0]};

  dcdds_sine_rom #(
    .QTR_BITS (QTR_BITS)
  ) u_sine_rom (
    .clk     (clk),
    .addr    (rom_addr),
    .rd_data (rom_q)
  );

  always_comb begin
    if (state == S_MUL_AMP) begin
      mul_a = PHASE_BITS'(cur_amp);
      mul_b = cur_mode ? dcdds_pkg::SQUARE_MAG : rom_q;
    end else begin
      mul_a = cur_step;
      mul_b = dt;
    end
  end

  // code = (2^23 +/- amp*mag) >> 16, sign from the phase's top bit in both modes
  assign amp_prod  = prod[SUM_W-1:0];
  assign level_sum = cur_phase[PHASE_BITS-1] ? (MID_SUM - amp_prod) : (MID_SUM + amp_prod);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_acc) begin
          case (dcdds_pkg::op_t'(s_axis_tuser))
            dcdds_pkg::OP_STOP: state_next = S_DONE;
            dcdds_pkg::OP_TICK: state_next = running ? S_MUL_STEP : S_IDLE;
            default:            state_next = S_IDLE;
          endcase
        end
      end
      S_MUL_STEP: state_next = S_ADD;
      S_ADD:      state_next = S_ROM;
      S_ROM:      state_next = S_MUL_AMP;
      S_MUL_AMP:  state_next = S_CODE;
      S_CODE:     state_next = ch ? S_DONE : S_MUL_STEP;
      S_DONE:     state_next = out_free ? S_IDLE : S_DONE;
      default:    state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      running   <= 1'b0;
      ch        <= 1'b0;
      phase_ch1 <= '0;
      phase_ch2 <= '0;
      step_ch1  <= '0;
      step_ch2  <= '0;
      start_ch1 <= '0;
      start_ch2 <= '0;
      amp_ch1   <= '0;
      amp_ch2   <= '0;
      mode_ch1  <= 1'b0;
      mode_ch2  <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_valid && cfg_ready) begin
        unique case (dcdds_pkg::cfg_idx_t'(cfg_index))
          dcdds_pkg::CFG_STEP_CH1:  step_ch1  <= PHASE_BITS'(cfg_data);
          dcdds_pkg::CFG_STEP_CH2:  step_ch2  <= PHASE_BITS'(cfg_data);
          dcdds_pkg::CFG_AMP_CH1:   amp_ch1   <= cfg_data[dcdds_pkg::AMP_W-1:0];
          dcdds_pkg::CFG_AMP_CH2:   amp_ch2   <= cfg_data[dcdds_pkg::AMP_W-1:0];
          dcdds_pkg::CFG_MODE_CH1:  mode_ch1  <= cfg_data[0];
          dcdds_pkg::CFG_MODE_CH2:  mode_ch2  <= cfg_data[0];
          dcdds_pkg::CFG_START_CH1: start_ch1 <= PHASE_BITS'(cfg_data);
          dcdds_pkg::CFG_START_CH2: start_ch2 <= PHASE_BITS'(cfg_data);
        endcase
      end

      if (state == S_IDLE && in_acc) begin
        ch <= 1'b0;
        case (dcdds_pkg::op_t'(s_axis_tuser))
          dcdds_pkg::OP_START: begin
            phase_ch1 <= '0 - start_ch1;
            phase_ch2 <= '0 - start_ch2;
            running   <= 1'b1;
          end
          dcdds_pkg::OP_STOP: running <= 1'b0;
          default: ;
        endcase
      end

      if (state == S_ADD) begin
        if (ch) begin
          phase_ch2 <= phase_ch2 + prod[PHASE_BITS-1:0];
        end else begin
          phase_ch1 <= phase_ch1 + prod[PHASE_BITS-1:0];
        end
      end

      if (state == S_CODE && !ch) begin
        ch <= 1'b1;
      end

      if (state == S_DONE && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_acc) begin
      dt <= s_axis_tdata;
      if (dcdds_pkg::op_t'(s_axis_tuser) == dcdds_pkg::OP_STOP) begin
        dac_ch1 <= dcdds_pkg::DAC_MID;
        dac_ch2 <= dcdds_pkg::DAC_MID;
      end
    end
    if (state == S_MUL_STEP || state == S_MUL_AMP) begin
      prod <= PROD_W'(mul_a) * PROD_W'(mul_b);
    end
    if (state == S_CODE) begin
      if (ch) begin
        dac_ch2 <= level_sum[SUM_W-1 -: dcdds_pkg::DAC_W];
      end else begin
        dac_ch1 <= level_sum[SUM_W-1 -: dcdds_pkg::DAC_W];
      end
    end
    if (state == S_DONE && out_free) begin
      m_axis_tdata <= {dac_ch2, dac_ch1};
    end
  end

endmodule
